// ===== src/quadratic_trend_mean_abs_error_macros.svh =====
// Assertion macros for the quadratic trend mean absolute error block.
`ifndef QUADRATIC_TREND_MEAN_ABS_ERROR_MACROS_SVH
`define QUADRATIC_TREND_MEAN_ABS_ERROR_MACROS_SVH
`ifndef SYNTH
`define QT_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define QT_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define QT_ASSERT_IMP(label, clk, rstn, a, c)
`define QT_ASSERT_NXT(label, clk, rstn, a, c)
`endif
`endif

// ===== src/qtmae_pkg.sv =====
// Shared types and constants for the quadratic trend mean absolute error block.
package qtmae_pkg;
    localparam int MAX_SAMPLES_DEF = 1048576;
    localparam int CNT_W = 21;
    localparam int SUM_W = 56;
    localparam int NUM_TERMS = 9;
    localparam int TERM_IDX_W = 4;
    localparam int DIV_STEPS = 56;
    localparam int DIV_IDX_W = 6;

    localparam logic [2:0] REG_XX_XY = 3'd0;
    localparam logic [2:0] REG_XZ_YY = 3'd1;
    localparam logic [2:0] REG_YZ_ZZ = 3'd2;
    localparam logic [2:0] REG_LIN_XY = 3'd3;
    localparam logic [2:0] REG_LIN_Z = 3'd4;
    localparam logic [2:0] REG_THREE_DIM = 3'd5;
    localparam logic [2:0] REG_NODATA_EN = 3'd6;
    localparam logic [2:0] REG_NODATA_VAL = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_ACCUM,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic term_step;
        logic accum;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic terms_done;
        logic div_done;
        logic keep;
        logic last;
    } status_t;
endpackage

// ===== src/qtmae_ctrl.sv =====
// Controller state machine that sequences term, accumulate and divide steps.
`include "quadratic_trend_mean_abs_error_macros.svh"
module qtmae_ctrl
    import qtmae_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);
    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_TERM;
            end
            ST_TERM: begin
                if (!status.keep) state_next = ST_ACCUM;
                else if (status.terms_done) state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                state_next = status.last ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (status.div_done && !mvalid_reg) state_next = ST_OUT;
            end
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_ready       = 1'b0;
        mvalid_next   = mvalid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_TERM: cmd.term_step = status.keep;
            ST_ACCUM: begin
                cmd.accum     = 1'b1;
                cmd.div_start = status.last;
            end
            ST_DIV:  cmd.div_step = !status.div_done;
            ST_OUT: begin
                cmd.out_load = 1'b1;
                mvalid_next  = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    assign m_valid = mvalid_reg;

    `QT_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `QT_ASSERT_NXT(a_out_sets_valid, aclk, aresetn, state_reg == ST_OUT, m_valid)
    `QT_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load, !mvalid_reg)
endmodule

// ===== src/qtmae_dp.sv =====
// Datapath: shared term multiplier, error accumulator and restoring divider.
module qtmae_dp
    import qtmae_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic signed [23:0] s_x_pos,
    input  logic signed [23:0] s_y_pos,
    input  logic signed [23:0] s_z_pos,
    input  logic signed [31:0] s_observed,
    input  logic               s_last_sample,
    input  cmd_t               cmd,
    output status_t            status,
    output logic [31:0]        m_mean_abs_error,
    output logic [CNT_W-1:0]   m_valid_count,
    output logic               m_empty_res
);
    localparam logic [CNT_W-1:0] COUNT_CAP =
        (MAX_SAMPLES < (2**CNT_W) - 1) ? CNT_W'(MAX_SAMPLES) : {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    logic [63:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic [31:0] c4_reg, ndv_reg;
    logic        three_reg, nde_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg <= '0; c1_reg <= '0; c2_reg <= '0; c3_reg <= '0;
            c4_reg <= '0; ndv_reg <= '0; three_reg <= 1'b1; nde_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_XX_XY:      c0_reg    <= cfg_data;
                REG_XZ_YY:      c1_reg    <= cfg_data;
                REG_YZ_ZZ:      c2_reg    <= cfg_data;
                REG_LIN_XY:     c3_reg    <= cfg_data;
                REG_LIN_Z:      c4_reg    <= cfg_data[31:0];
                REG_THREE_DIM:  three_reg <= cfg_data[0];
                REG_NODATA_EN:  nde_reg   <= cfg_data[0];
                REG_NODATA_VAL: ndv_reg   <= cfg_data[31:0];
                default:        c4_reg    <= c4_reg;
            endcase
        end
    end

    logic signed [23:0] x_reg, y_reg, z_reg;
    logic signed [31:0] obs_reg;
    logic               last_reg, keep_reg;
    logic [TERM_IDX_W-1:0] tidx_reg;
    logic signed [63:0] pred_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [32:0] nd_diff;
    logic               skip;

    assign nd_diff = {s_observed[31], s_observed} - {ndv_reg[31], ndv_reg};
    assign skip = nde_reg && (nd_diff >= -33'sd1) && (nd_diff <= 33'sd1);

    // operand selection for the term in flight
    logic signed [31:0] coef;
    logic signed [47:0] opnd;
    logic               term_on;
    logic signed [23:0] xs, ys, zs;
    assign xs = x_reg; assign ys = y_reg; assign zs = z_reg;

    always_comb begin
        coef = '0; opnd = '0; term_on = 1'b1;
        case (tidx_reg)
            4'd0: begin coef = c0_reg[63:32]; opnd = xs * xs; end
            4'd1: begin coef = c0_reg[31:0];  opnd = xs * ys; end
            4'd2: begin coef = c1_reg[31:0];  opnd = ys * ys; end
            4'd3: begin coef = c3_reg[63:32]; opnd = 48'(xs) <<< 8; end
            4'd4: begin coef = c3_reg[31:0];  opnd = 48'(ys) <<< 8; end
            4'd5: begin coef = c1_reg[63:32]; opnd = xs * zs; term_on = three_reg; end
            4'd6: begin coef = c2_reg[63:32]; opnd = ys * zs; term_on = three_reg; end
            4'd7: begin coef = c2_reg[31:0];  opnd = zs * zs; term_on = three_reg; end
            4'd8: begin coef = c4_reg;        opnd = 48'(zs) <<< 8; term_on = three_reg; end
            default: term_on = 1'b0;
        endcase
    end

    // operand register, then two partial products on the upper and lower
    // operand halves, then the floor shift folded into the accumulate
    logic signed [47:0] opnd_reg;
    logic signed [31:0] coef_reg;
    logic               on_reg, pvalid_reg;
    logic signed [55:0] phi;
    logic signed [56:0] plo;
    logic signed [55:0] phi_reg;
    logic signed [56:0] plo_reg;
    logic               on2_reg, pvalid2_reg;

    assign phi = coef_reg * $signed(opnd_reg[47:24]);
    assign plo = coef_reg * $signed({1'b0, opnd_reg[23:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg  <= 1'b0;
            pvalid2_reg <= 1'b0;
        end else begin
            pvalid_reg  <= cmd.term_step && (tidx_reg < TERM_IDX_W'(NUM_TERMS));
            pvalid2_reg <= pvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        opnd_reg <= opnd;
        coef_reg <= coef;
        on_reg   <= term_on;
        phi_reg  <= phi;
        plo_reg  <= plo;
        on2_reg  <= on_reg;
    end

    assign status.terms_done = (tidx_reg == TERM_IDX_W'(NUM_TERMS)) && !pvalid_reg
                               && !pvalid2_reg;
    assign status.keep = keep_reg;
    assign status.last = last_reg;

    logic signed [64:0] err;
    logic [63:0] mag;
    assign err = {obs_reg[31], {32{obs_reg[31]}}, obs_reg} - {pred_reg[63], pred_reg};
    assign mag = err[64] ? 64'(-err) : err[63:0];

    // divider
    logic [SUM_W-1:0] dq_reg;
    logic [CNT_W:0]   drem_reg;
    logic [DIV_IDX_W-1:0] dcnt_reg;
    logic             dbusy_reg;
    logic [CNT_W:0]   dtrial;
    assign dtrial = {drem_reg[CNT_W-1:0], dq_reg[SUM_W-1]};
    assign status.div_done = !dbusy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            cnt_reg   <= '0;
            tidx_reg  <= '0;
            dbusy_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                x_reg    <= s_x_pos; y_reg <= s_y_pos; z_reg <= s_z_pos;
                obs_reg  <= s_observed;
                last_reg <= s_last_sample;
                keep_reg <= !skip && (cnt_reg < COUNT_CAP);
                tidx_reg <= '0;
                pred_reg <= '0;
            end
            if (cmd.term_step && tidx_reg < TERM_IDX_W'(NUM_TERMS))
                tidx_reg <= tidx_reg + 1'b1;
            if (pvalid2_reg && on2_reg)
                pred_reg <= pred_reg + 64'(phi_reg) + 64'(plo_reg >>> 24);
            if (cmd.accum && keep_reg) begin
                if (mag >= 64'(SUM_MAX) || sum_reg > SUM_MAX - mag[SUM_W-1:0])
                    sum_reg <= SUM_MAX;
                else
                    sum_reg <= sum_reg + mag[SUM_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.div_start) begin
                dq_reg    <= (cmd.accum && keep_reg) ?
                             ((mag >= 64'(SUM_MAX) || sum_reg > SUM_MAX - mag[SUM_W-1:0])
                              ? SUM_MAX : sum_reg + mag[SUM_W-1:0]) : sum_reg;
                drem_reg  <= '0;
                dcnt_reg  <= '0;
                dbusy_reg <= 1'b1;
            end
            if (cmd.div_step) begin
                if (dtrial >= {1'b0, cnt_reg}) begin
                    drem_reg <= dtrial - {1'b0, cnt_reg};
                    dq_reg   <= {dq_reg[SUM_W-2:0], 1'b1};
                end else begin
                    drem_reg <= dtrial;
                    dq_reg   <= {dq_reg[SUM_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_IDX_W'(DIV_STEPS - 1)) dbusy_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_empty_res      <= (cnt_reg == '0);
            m_valid_count    <= cnt_reg;
            m_mean_abs_error <= (cnt_reg == '0) ? 32'd0 :
                                (|dq_reg[SUM_W-1:32]) ? 32'hFFFF_FFFF : dq_reg[31:0];
        end
    end
endmodule

// ===== src/quadratic_trend_mean_abs_error.sv =====
// Top level of the quadratic trend mean absolute error block.
// A kept sample passes through load, nine terms issued one per cycle to a
// shared coefficient multiplier split into two partial products, a wait
// while that pipeline drains, and an accumulate step. A skipped sample
// (no-data match or full count) goes through load, the term state with no
// terms issued, and accumulate. A sample flagged last then runs the restoring divide (56 quotient bits and a finish
// check), held further while an earlier result beat waits for m_ready, and
// the output state; the next sample is taken once the result register is loaded.
module quadratic_trend_mean_abs_error
    import qtmae_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_x_pos,
    input  logic signed [23:0] s_y_pos,
    input  logic signed [23:0] s_z_pos,
    input  logic signed [31:0] s_observed,
    input  logic               s_last_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_mean_abs_error,
    output logic [CNT_W-1:0]   m_valid_count,
    output logic               m_empty_res
);
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    qtmae_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .status(status), .cmd(cmd)
    );

    qtmae_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_x_pos(s_x_pos), .s_y_pos(s_y_pos), .s_z_pos(s_z_pos),
        .s_observed(s_observed), .s_last_sample(s_last_sample),
        .cmd(cmd), .status(status),
        .m_mean_abs_error(m_mean_abs_error), .m_valid_count(m_valid_count),
        .m_empty_res(m_empty_res)
    );
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the quadratic trend mean absolute error block.
`timescale 1ns / 1ps

module tb
    import qtmae_pkg::*;
();

    typedef struct {
        logic [31:0]      mean;
        logic [CNT_W-1:0] count;
        logic             empty;
    } mae_result_t;

    class mae_scoreboard;
        logic [63:0] coef [8];
        logic [55:0] err_sum;
        logic [CNT_W-1:0] n_kept;
        mae_result_t pending[$];
        int mismatches;

        function new();
            int k;
            for (k = 0; k < 8; k++) coef[k] = '0;
            coef[REG_THREE_DIM] = 64'd1;
            err_sum = '0;
            n_kept = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            if (idx == REG_LIN_Z || idx == REG_NODATA_VAL) val = {32'd0, val[31:0]};
            else if (idx == REG_THREE_DIM || idx == REG_NODATA_EN) val = {63'd0, val[0]};
            coef[idx] = val;
        endfunction

        // floor(c * b / 2^24)
        function longint term(logic [31:0] c, longint b);
            logic signed [127:0] p;
            p = $signed(c) * 128'(signed'(b));
            p = p >>> 24;
            return longint'(p);
        endfunction

        function void note_sample(logic signed [23:0] xs, logic signed [23:0] ys,
                                  logic signed [23:0] zs, logic signed [31:0] obs,
                                  logic last);
            longint x, y, z, pred, err, diff;
            logic [63:0] mag;
            logic [63:0] q;
            mae_result_t r;
            x = xs; y = ys; z = zs;
            diff = longint'(obs) - longint'($signed(coef[REG_NODATA_VAL][31:0]));
            if (!(coef[REG_NODATA_EN][0] && diff >= -1 && diff <= 1)
                    && n_kept < CNT_W'(MAX_SAMPLES_DEF)) begin
                pred = term(coef[REG_XX_XY][63:32], x * x)
                     + term(coef[REG_XX_XY][31:0], x * y)
                     + term(coef[REG_XZ_YY][31:0], y * y)
                     + term(coef[REG_LIN_XY][63:32], x * 256)
                     + term(coef[REG_LIN_XY][31:0], y * 256);
                if (coef[REG_THREE_DIM][0]) begin
                    pred += term(coef[REG_XZ_YY][63:32], x * z)
                          + term(coef[REG_YZ_ZZ][63:32], y * z)
                          + term(coef[REG_YZ_ZZ][31:0], z * z)
                          + term(coef[REG_LIN_Z][31:0], z * 256);
                end
                err = longint'(obs) - pred;
                mag = err < 0 ? -err : err;
                if (mag >= 64'h00FF_FFFF_FFFF_FFFF
                        || 64'(err_sum) > 64'h00FF_FFFF_FFFF_FFFF - mag)
                    err_sum = '1;
                else
                    err_sum += mag[55:0];
                n_kept++;
            end
            if (!last) return;
            if (n_kept == 0) begin
                r.mean = '0; r.count = '0; r.empty = 1'b1;
            end else begin
                q = 64'(err_sum) / 64'(n_kept);
                r.mean = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
                r.count = n_kept;
                r.empty = 1'b0;
            end
            pending = {pending, r};
            err_sum = '0;
            n_kept = '0;
        endfunction

        function void check(logic [31:0] mean, logic [CNT_W-1:0] count, logic empty);
            mae_result_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat mean=%h", mean);
                return;
            end
            e = pending.pop_front();
            if (mean !== e.mean || count !== e.count || empty !== e.empty) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp %h/%0d/%b got %h/%0d/%b",
                             e.mean, e.count, e.empty, mean, count, empty);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [23:0] s_x_pos = '0, s_y_pos = '0, s_z_pos = '0;
    logic signed [31:0] s_observed = '0;
    logic s_last_sample = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] m_mean_abs_error;
    logic [CNT_W-1:0] m_valid_count;
    logic m_empty_res;

    mae_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 1'b0;
    longint cycles = 0;

    always #4 aclk = ~aclk;

    quadratic_trend_mean_abs_error i_dut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3_000_000) begin
            $display("FAIL quadratic_trend_mean_abs_error");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check(m_mean_abs_error, m_valid_count, m_empty_res);
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send(logic signed [23:0] x, logic signed [23:0] y,
                        logic signed [23:0] z, logic signed [31:0] obs, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_x_pos <= x; s_y_pos <= y; s_z_pos <= z;
        s_observed <= obs; s_last_sample <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(x, y, z, obs, last);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_coef(int mode);
        case (mode)
            0: return {$urandom, $urandom};
            1: return {{8{$urandom_range(1) ? 8'hFF : 8'h00}}} ^ {2{32'(24'($urandom))}};
            default: return {32'($signed(24'($urandom)) >>> 6), 32'($signed(24'($urandom)) >>> 6)};
        endcase
    endfunction

    task automatic rand_config(int mode);
        int k;
        for (k = 0; k < 5; k++) write_cfg(3'(k), rand_coef(mode));
        write_cfg(REG_THREE_DIM, 64'($urandom_range(1)));
        write_cfg(REG_NODATA_EN, 64'($urandom_range(1)));
        write_cfg(REG_NODATA_VAL, {$urandom, $urandom});
    endtask

    task automatic rand_sets(int n_items);
        int k, len;
        logic signed [31:0] obs;
        logic signed [23:0] x, y, z;
        k = 0;
        while (k < n_items) begin
            len = $urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(6, 1);
            for (int j = 0; j < len; j++) begin
                case ($urandom_range(7))
                    0: obs = sb.coef[REG_NODATA_VAL][31:0] + $signed($urandom_range(2)) - 1;
                    1: obs = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: obs = $urandom;
                endcase
                x = $urandom_range(3) == 0 ? 24'($urandom) : 24'($signed(12'($urandom)));
                y = $urandom_range(3) == 0 ? 24'($urandom) : 24'($signed(12'($urandom)));
                z = $urandom_range(3) == 0 ? 24'($urandom) : 24'($signed(12'($urandom)));
                send(x, y, z, obs, j == len - 1);
                k++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config, empty set, extremes
        send('0, '0, '0, 32'sd5, 1'b1);
        send(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'h8000_0000, 1'b0);
        send(24'h800000, 24'h7FFFFF, 24'h800000, 32'h7FFF_FFFF, 1'b1);
        drain();
        write_cfg(REG_XX_XY, 64'h7FFF_FFFF_8000_0000);
        write_cfg(REG_XZ_YY, 64'h8000_0000_7FFF_FFFF);
        write_cfg(REG_YZ_ZZ, 64'h7FFF_FFFF_7FFF_FFFF);
        write_cfg(REG_LIN_XY, 64'h8000_0000_8000_0000);
        write_cfg(REG_LIN_Z, 64'h8000_0000);
        write_cfg(REG_NODATA_EN, 64'd1);
        write_cfg(REG_NODATA_VAL, 64'h8000_0000);
        for (int k = 0; k < 4; k++)
            send(24'h800000, 24'h800000, 24'h800000, 32'h7FFF_FFFF, 1'b0);
        send(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'h8000_0000, 1'b1);
        send('0, '0, '0, 32'h8000_0001, 1'b1);
        drain();
        write_cfg(REG_THREE_DIM, 64'd0);
        write_cfg(REG_NODATA_VAL, 64'h0000_0100);
        send(24'h123456, 24'hFEDCBA, 24'h7FFFFF, 32'h0000_00FF, 1'b0);
        send(24'h000100, 24'h000200, 24'h800000, 32'h0000_0101, 1'b0);
        send(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'h0000_0100, 1'b0);
        send(24'hFFFFFF, 24'h000001, 24'h000000, 32'h0000_0102, 1'b1);
        send(24'h000001, 24'hFFFFFF, 24'h000000, 32'h0000_0103, 1'b1);
        drain();

        send_idle_pct = 20; recv_idle_pct = 81;
        rand_config(2); rand_sets(400); drain();
        rand_config(0); rand_sets(250); drain();

        // long receiver stall while samples keep coming
        hold_off = 1'b1;
        fork
            begin repeat (3000) @(posedge aclk); hold_off = 1'b0; end
            rand_sets(300);
        join
        drain();

        send_idle_pct = 81; recv_idle_pct = 20;
        rand_config(1); rand_sets(300); drain();
        rand_config(2); rand_sets(200); drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        rand_config(2); rand_sets(300); drain();
        rand_config(0); rand_sets(200); drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS quadratic_trend_mean_abs_error");
        else
            $display("FAIL quadratic_trend_mean_abs_error");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/qtmae_pkg.sv
src/qtmae_ctrl.sv
src/qtmae_dp.sv
src/quadratic_trend_mean_abs_error.sv
verif/tb.sv
